FILE: hw/rtl/rmt_pkg.sv
// Shared types, constants and the heap ordering function for the running median tracker.
`timescale 1ns / 1ps
`default_nettype none

package rmt_pkg;

	localparam int SAMPLE_W     = 32;
	localparam int MEDIAN_W     = 33;
	localparam int HELD_W       = 11;
	localparam int CAPACITY_DEF = 1024;
	localparam int CAPACITY_MAX = 65536;

	// Heap node numbers are 1-based; the widest heap holds half the largest capacity.
	localparam int NODE_W = $clog2(CAPACITY_MAX / 2 + 1);
	localparam int LVL_W  = $clog2(NODE_W);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [NODE_W-1:0]          node_t;

	typedef enum logic {
		OP_INSERT,
		OP_SIFT
	} heap_op_t;

	// Work token that walks down the levels of one heap.
	typedef struct packed {
		logic     vld;
		heap_op_t op;
		sample_t  value;
		node_t    node;
	} heap_tok_t;

	// Value for a parent node, handed back up by the level below it.
	typedef struct packed {
		logic    vld;
		sample_t value;
		node_t   node;
	} heap_wb_t;

	function automatic logic ranks_ahead(input sample_t a, input sample_t b, input logic is_max);
		return is_max ? (a > b) : (a < b);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rmt_cell.sv
// One heap level: sibling-pair memory plus the compare and swap step for that level.
`timescale 1ns / 1ps
`default_nettype none

module rmt_cell import rmt_pkg::*; #(
	parameter int LEVEL  = 1,
	parameter bit IS_MAX = 1'b1
) (
	input  wire              clk,
	input  wire              arst_n,
	input  heap_tok_t        tok_in,
	output heap_tok_t        tok_out,
	input  heap_wb_t         wb_in,
	output heap_wb_t         wb_out,
	input  node_t            count,
	input  node_t            target,
	input  logic [LVL_W-1:0] target_lvl,
	output logic             busy
);

	localparam int    ROWS = 1 << (LEVEL - 1);
	localparam int    AW   = (LEVEL > 1) ? (LEVEL - 1) : 1;
	localparam node_t BASE = node_t'(ROWS);

	// Each row holds the two children of one node of the level above.
	sample_t mem_l [ROWS];
	sample_t mem_r [ROWS];

	sample_t   rd_l_q;
	sample_t   rd_r_q;
	heap_tok_t cur_q;
	heap_tok_t tok_out_q;
	logic      busy_q;

	logic [AW-1:0]    rd_row;
	logic [AW-1:0]    cur_row;
	logic [AW-1:0]    wb_row;
	logic [LVL_W-1:0] tsel;
	logic             path_bit;
	logic             at_tgt;
	logic [NODE_W:0]  cnt_x;
	logic             has_l;
	logic             has_r;
	logic             best;
	sample_t          cb;
	sample_t          child;
	node_t            qb;
	node_t            qpath;
	logic             leaf;

	heap_tok_t        tok_nxt;
	logic             self_en;
	logic             self_half;
	sample_t          self_data;

	logic             wr_en;
	logic             wr_half;
	logic [AW-1:0]    wr_row;
	sample_t          wr_data;

	assign rd_row  = AW'(tok_in.node ^ BASE);
	assign cur_row = AW'(cur_q.node ^ BASE);
	assign wb_row  = AW'((wb_in.node >> 1) ^ BASE);

	assign tsel     = target_lvl - LVL_W'(LEVEL);
	assign path_bit = target[tsel];
	assign at_tgt   = (target_lvl == LVL_W'(LEVEL));
	assign qpath    = {cur_q.node[NODE_W-2:0], path_bit};
	assign child    = path_bit ? rd_r_q : rd_l_q;

	assign cnt_x = {1'b0, count};
	assign has_l = {cur_q.node, 1'b0} <= cnt_x;
	assign has_r = {cur_q.node, 1'b1} <= cnt_x;
	assign best  = has_r && ranks_ahead(rd_r_q, rd_l_q, IS_MAX);
	assign cb    = best ? rd_r_q : rd_l_q;
	assign qb    = {cur_q.node[NODE_W-2:0], best};
	// A child with no children of its own takes the sifted value right here.
	assign leaf  = {qb, 1'b0} > cnt_x;

	always_comb begin
		tok_nxt   = '0;
		wb_out    = '0;
		self_en   = 1'b0;
		self_half = 1'b0;
		self_data = cur_q.value;
		if (busy_q) begin
			unique case (cur_q.op)
				OP_INSERT: begin
					if (at_tgt) begin
						self_en   = 1'b1;
						self_half = path_bit;
					end else if (ranks_ahead(cur_q.value, child, IS_MAX)) begin
						self_en   = 1'b1;
						self_half = path_bit;
						tok_nxt   = '{vld: 1'b1, op: OP_INSERT, value: child, node: qpath};
					end else begin
						tok_nxt   = '{vld: 1'b1, op: OP_INSERT, value: cur_q.value, node: qpath};
					end
				end
				OP_SIFT: begin
					if (!has_l || !ranks_ahead(cb, cur_q.value, IS_MAX)) begin
						wb_out = '{vld: 1'b1, value: cur_q.value, node: cur_q.node};
					end else begin
						wb_out = '{vld: 1'b1, value: cb, node: cur_q.node};
						if (leaf) begin
							self_en   = 1'b1;
							self_half = best;
						end else begin
							tok_nxt = '{vld: 1'b1, op: OP_SIFT, value: cur_q.value, node: qb};
						end
					end
				end
			endcase
		end
	end

	// The level below writes back only after this level has finished its own step.
	always_comb begin
		if (wb_in.vld) begin
			wr_en   = 1'b1;
			wr_half = wb_in.node[0];
			wr_row  = wb_row;
			wr_data = wb_in.value;
		end else begin
			wr_en   = self_en;
			wr_half = self_half;
			wr_row  = cur_row;
			wr_data = self_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !wr_half) begin
			mem_l[wr_row] <= wr_data;
		end
		if (wr_en && wr_half) begin
			mem_r[wr_row] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			rd_l_q <= mem_l[rd_row];
			rd_r_q <= mem_r[rd_row];
			cur_q  <= tok_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			tok_out_q <= '0;
		end else begin
			busy_q    <= tok_in.vld;
			tok_out_q <= tok_nxt;
		end
	end

	assign tok_out = tok_out_q;
	assign busy    = busy_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rmt_heap.sv
// One binary heap: root register, element count and the chain of level cells below the root.
`timescale 1ns / 1ps
`default_nettype none

module rmt_heap import rmt_pkg::*; #(
	parameter  int DEPTH  = CAPACITY_DEF / 2,
	parameter  bit IS_MAX = 1'b1,
	localparam int CNT_W  = $clog2(DEPTH + 1)
) (
	input  wire              clk,
	input  wire              arst_n,
	input  logic             start,
	input  heap_op_t         op,
	input  sample_t          value,
	output sample_t          top,
	output logic [CNT_W-1:0] count,
	output logic             busy
);

	localparam int LEVELS = ($clog2(DEPTH + 1) > 2) ? $clog2(DEPTH + 1) : 2;

	logic [CNT_W-1:0] count_q;
	sample_t          root_q;
	node_t            target_q;
	logic [LVL_W-1:0] tlvl_q;
	heap_tok_t        tok_q;

	node_t            new_node;
	logic [LVL_W-1:0] new_lvl;
	logic             root_ahead;
	node_t            cnt_n;

	heap_tok_t        link [1:LEVELS];
	heap_wb_t         wbk  [1:LEVELS];
	logic [LEVELS-1:1] cell_busy;

	// An insert walks from the root toward the new last slot.
	assign new_node   = node_t'(count_q) + node_t'(1);
	assign root_ahead = ranks_ahead(value, root_q, IS_MAX);
	assign cnt_n      = node_t'(count_q);

	always_comb begin
		new_lvl = '0;
		for (int i = 0; i < NODE_W; i++) begin
			if (new_node[i]) begin
				new_lvl = LVL_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tok_q   <= '0;
		end else begin
			tok_q <= '0;
			if (start) begin
				if (op == OP_INSERT) begin
					count_q <= count_q + CNT_W'(1);
					if (count_q != '0) begin
						tok_q <= '{vld: 1'b1, op: OP_INSERT,
							value: root_ahead ? root_q : value, node: node_t'(1)};
					end
				end else begin
					tok_q <= '{vld: 1'b1, op: OP_SIFT, value: value, node: node_t'(1)};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && op == OP_INSERT) begin
			target_q <= new_node;
			tlvl_q   <= new_lvl;
			if (count_q == '0 || root_ahead) begin
				root_q <= value;
			end
		end else if (wbk[1].vld) begin
			root_q <= wbk[1].value;
		end
	end

	assign link[1]      = tok_q;
	assign wbk[LEVELS]  = '0;

	for (genvar k = 1; k < LEVELS; k++) begin : g_cell
		rmt_cell #(
			.LEVEL  (k),
			.IS_MAX (IS_MAX)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tok_in     (link[k]),
			.tok_out    (link[k+1]),
			.wb_in      (wbk[k+1]),
			.wb_out     (wbk[k]),
			.count      (cnt_n),
			.target     (target_q),
			.target_lvl (tlvl_q),
			.busy       (cell_busy[k])
		);
	end

	always_comb begin
		busy = 1'b0;
		for (int k = 1; k <= LEVELS; k++) begin
			busy = busy | link[k].vld;
		end
		for (int k = 1; k < LEVELS; k++) begin
			busy = busy | cell_busy[k];
		end
	end

	assign top   = root_q;
	assign count = count_q;

endmodule

`default_nettype wire

FILE: hw/rtl/running_median_tracker_top.sv
// Top level of the running median tracker: two heaps, item control and the result register.
// A dropped sample skips the heap walk; any other sample waits until both heaps are idle. A new
// beat is taken once the result is registered, which waits for the output to be free.
// The time is set by the walk down the deeper heap, each level doing the registered memory
// read and then the compare and write. Reset clears both counts and all control state;
// heap memories are not cleared, since only entries below the counts are ever read.
`timescale 1ns / 1ps
`default_nettype none

module running_median_tracker_top import rmt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  sample_t                     sample,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic signed [MEDIAN_W-1:0]  median_doubled,
	output logic        [HELD_W-1:0]    held_count,
	output logic                        dropped
);

	localparam int HALF  = (CAPACITY + 1) / 2;
	localparam int CNT_W = $clog2(HALF + 1);
	localparam int TOT_W = $clog2(CAPACITY + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	sample_t          ltop;
	sample_t          utop;
	logic [CNT_W-1:0] lcnt;
	logic [CNT_W-1:0] ucnt;
	logic             lo_busy;
	logic             up_busy;

	logic             lo_start;
	logic             up_start;
	heap_op_t         lo_op;
	heap_op_t         up_op;
	sample_t          lo_val;
	sample_t          up_val;

	logic [TOT_W-1:0] total;
	logic             full;
	logic             eq;
	logic             accept;
	logic             out_free;
	logic             drop_q;
	logic             rvalid_q;
	logic signed [MEDIAN_W-1:0] median_q;
	logic [HELD_W-1:0] held_q;
	logic             dropped_q;
	logic signed [MEDIAN_W-1:0] median_nxt;

	assign total    = TOT_W'(lcnt) + TOT_W'(ucnt);
	assign full     = total >= TOT_W'(CAPACITY);
	assign eq       = (lcnt == ucnt);
	assign accept   = sample_valid && sample_ready;
	assign out_free = !rvalid_q || result_ready;

	// The lower heap keeps the extra sample when the count is odd.
	always_comb begin
		lo_start = 1'b0;
		up_start = 1'b0;
		lo_op    = OP_INSERT;
		up_op    = OP_INSERT;
		lo_val   = sample;
		up_val   = sample;
		if (accept && !full) begin
			if (eq) begin
				lo_start = 1'b1;
				if (!(lcnt == '0 || sample <= utop)) begin
					lo_val   = utop;
					up_start = 1'b1;
					up_op    = OP_SIFT;
				end
			end else begin
				up_start = 1'b1;
				if (sample < ltop) begin
					up_val   = ltop;
					lo_start = 1'b1;
					lo_op    = OP_SIFT;
				end
			end
		end
	end

	rmt_heap #(
		.DEPTH  (HALF),
		.IS_MAX (1'b1)
	) u_lower (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lo_start),
		.op     (lo_op),
		.value  (lo_val),
		.top    (ltop),
		.count  (lcnt),
		.busy   (lo_busy)
	);

	rmt_heap #(
		.DEPTH  (HALF),
		.IS_MAX (1'b0)
	) u_upper (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (up_start),
		.op     (up_op),
		.value  (up_val),
		.top    (utop),
		.count  (ucnt),
		.busy   (up_busy)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = full ? ST_DONE : ST_RUN;
				end
			end
			ST_RUN: begin
				if (!lo_busy && !up_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				rvalid_q <= 1'b1;
			end else if (result_ready) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	// Twice the median keeps the half-way value exact.
	assign median_nxt = eq ? ({ltop[SAMPLE_W-1], ltop} + {utop[SAMPLE_W-1], utop})
		: {ltop, 1'b0};

	always_ff @(posedge clk) begin
		if (accept) begin
			drop_q <= full;
		end
		if (state_q == ST_DONE && out_free) begin
			median_q  <= median_nxt;
			held_q    <= HELD_W'(total);
			dropped_q <= drop_q;
		end
	end

	assign sample_ready   = (state_q == ST_IDLE);
	assign result_valid   = rvalid_q;
	assign median_doubled = median_q;
	assign held_count     = held_q;
	assign dropped        = dropped_q;

	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((lcnt == ucnt) || (lcnt == ucnt + CNT_W'(1))))
		else $error("heap counts out of balance");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) && (ucnt != '0)) |-> (ltop <= utop))
		else $error("lower heap top above upper heap top");

	a_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!lo_busy && !up_busy))
		else $error("heap still working while idle");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total <= TOT_W'(CAPACITY))
		else $error("held count above capacity");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the running median tracker with its own two-heap prediction.
`timescale 1ns / 1ps

module testbench;
	import rmt_pkg::*;

	localparam int CAPACITY      = CAPACITY_DEF;
	localparam int HALF_DEPTH    = CAPACITY / 2 + 1;
	localparam int TOTAL_SAMPLES = 1950;
	localparam int DRAIN_PAUSE   = 1200;
	localparam int QUIET_FIRST   = 400;
	localparam int QUIET_LAST    = 600;
	localparam int LONG_HOLD     = 500;
	localparam int HOLD_AT       = 150;
	localparam int SETTLE_CYCLES = 64;
	localparam int DRAIN_LIMIT   = 20000;
	localparam longint TIMEOUT_NS = 64'd10_000_000;

	typedef enum int {
		LOWER_HALF,
		UPPER_HALF
	} half_t;

	typedef struct packed {
		logic signed [MEDIAN_W-1:0] median;
		logic        [HELD_W-1:0]   held;
		logic                       dropped;
	} median_result_t;

	typedef struct packed {
		sample_t        value;
		logic           typed;
		median_result_t result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	sample_t sample;
	logic result_valid;
	logic result_ready;
	logic signed [MEDIAN_W-1:0] median_doubled;
	logic [HELD_W-1:0] held_count;
	logic dropped;

	// Predictor state: the lower half is a max-heap, the upper half a min-heap.
	sample_t heap_mem [2][HALF_DEPTH];
	int heap_count [2];

	median_result_t expected_medians [$];
	stim_row_t directed_rows [$];
	median_result_t seen;
	median_result_t want;

	int failures = 0;
	int results_checked = 0;
	int samples_sent = 0;
	int drops_predicted = 0;
	int peak_held = 0;

	running_median_tracker_top #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.median_doubled(median_doubled),
		.held_count(held_count),
		.dropped(dropped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit outranks(input half_t h, input sample_t a, input sample_t b);
		if (h == LOWER_HALF)
			return a > b;
		return a < b;
	endfunction

	function automatic void heap_insert(input half_t h, input sample_t value);
		int i;
		int p;
		sample_t t;
		i = heap_count[h];
		if (i >= HALF_DEPTH)
			return;
		heap_mem[h][i] = value;
		heap_count[h] = i + 1;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!outranks(h, heap_mem[h][i], heap_mem[h][p]))
				break;
			t = heap_mem[h][i];
			heap_mem[h][i] = heap_mem[h][p];
			heap_mem[h][p] = t;
			i = p;
		end
	endfunction

	function automatic void heap_remove_top(input half_t h);
		int n;
		int i;
		int l;
		int r;
		int best;
		sample_t t;
		n = heap_count[h];
		if (n == 0)
			return;
		n = n - 1;
		heap_count[h] = n;
		heap_mem[h][0] = heap_mem[h][n];
		i = 0;
		forever begin
			l = 2 * i + 1;
			r = l + 1;
			best = i;
			if (l < n && outranks(h, heap_mem[h][l], heap_mem[h][best]))
				best = l;
			if (r < n && outranks(h, heap_mem[h][r], heap_mem[h][best]))
				best = r;
			if (best == i)
				break;
			t = heap_mem[h][i];
			heap_mem[h][i] = heap_mem[h][best];
			heap_mem[h][best] = t;
			i = best;
		end
	endfunction

	// Adds one sample to the predicted set and returns the median report it causes.
	function automatic median_result_t track_median(input sample_t value);
		median_result_t res;
		sample_t lo_top;
		sample_t hi_top;
		res = '0;
		if (heap_count[LOWER_HALF] + heap_count[UPPER_HALF] >= CAPACITY) begin
			res.dropped = 1'b1;
		end else if (heap_count[LOWER_HALF] == heap_count[UPPER_HALF]) begin
			if (heap_count[LOWER_HALF] == 0 || value < heap_mem[LOWER_HALF][0]) begin
				heap_insert(LOWER_HALF, value);
			end else begin
				heap_insert(UPPER_HALF, value);
				heap_insert(LOWER_HALF, heap_mem[UPPER_HALF][0]);
				heap_remove_top(UPPER_HALF);
			end
		end else begin
			if (value >= heap_mem[LOWER_HALF][0]) begin
				heap_insert(UPPER_HALF, value);
			end else begin
				heap_insert(LOWER_HALF, value);
				heap_insert(UPPER_HALF, heap_mem[LOWER_HALF][0]);
				heap_remove_top(LOWER_HALF);
			end
		end
		lo_top = heap_mem[LOWER_HALF][0];
		hi_top = heap_mem[UPPER_HALF][0];
		if (heap_count[LOWER_HALF] > 0) begin
			if (heap_count[LOWER_HALF] == heap_count[UPPER_HALF])
				res.median = $signed({lo_top[SAMPLE_W-1], lo_top})
					+ $signed({hi_top[SAMPLE_W-1], hi_top});
			else
				res.median = $signed({lo_top, 1'b0});
		end
		res.held = HELD_W'(heap_count[LOWER_HALF] + heap_count[UPPER_HALF]);
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit in_quiet_stretch(input int n);
		return n >= QUIET_FIRST && n < QUIET_LAST;
	endfunction

	// Mix of wide random values, tight clusters full of duplicates, extremes, small steps from the last
	// value and values right around the current median, so the heaps see ties and deep sifts alike.
	function automatic sample_t draw_sample(input sample_t last);
		int kind;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2: return sample_t'($urandom);
			3, 4: return sample_t'(int'($urandom_range(0, 16)) - 8);
			5: begin
				case ($urandom_range(0, 4))
					0: return sample_t'(32'h8000_0000);
					1: return sample_t'(32'h7FFF_FFFF);
					2: return sample_t'(-1);
					3: return sample_t'(1);
					default: return sample_t'(0);
				endcase
			end
			6, 7: begin
				if (heap_count[LOWER_HALF] == 0)
					return sample_t'($urandom);
				return heap_mem[LOWER_HALF][0] + sample_t'(int'($urandom_range(0, 6)) - 3);
			end
			default: return last + sample_t'(int'($urandom_range(0, 200)) - 100);
		endcase
	endfunction

	task automatic add_row(input sample_t value, input bit typed,
			input logic signed [MEDIAN_W-1:0] median, input logic [HELD_W-1:0] held);
		stim_row_t row;
		row.value = value;
		row.typed = typed;
		row.result.median = median;
		row.result.held = held;
		row.result.dropped = 1'b0;
		directed_rows = {directed_rows, row};
	endtask

	task automatic build_directed_rows();
		// Sorted so far: min; then min, max; then min, max, max; then min, 0, max, max.
		add_row(sample_t'(32'h8000_0000), 1'b1, 33'sh1_0000_0000, 11'd1);
		add_row(sample_t'(32'h7FFF_FFFF), 1'b1, -33'sd1, 11'd2);
		add_row(sample_t'(32'h7FFF_FFFF), 1'b1, 33'sd4294967294, 11'd3);
		add_row(sample_t'(0), 1'b1, 33'sd2147483647, 11'd4);
		add_row(sample_t'(0), 1'b0, '0, '0);
		add_row(sample_t'(0), 1'b0, '0, '0);
		add_row(sample_t'(0), 1'b0, '0, '0);
		add_row(sample_t'(-1), 1'b0, '0, '0);
		add_row(sample_t'(1), 1'b0, '0, '0);
		add_row(sample_t'(32'h5555_5555), 1'b0, '0, '0);
		add_row(sample_t'(32'hAAAA_AAAA), 1'b0, '0, '0);
		add_row(sample_t'(32'h8000_0001), 1'b0, '0, '0);
		add_row(sample_t'(32'h7FFF_FFFE), 1'b0, '0, '0);
		add_row(sample_t'(100), 1'b0, '0, '0);
		add_row(sample_t'(99), 1'b0, '0, '0);
		add_row(sample_t'(98), 1'b0, '0, '0);
		add_row(sample_t'(97), 1'b0, '0, '0);
		add_row(sample_t'(-5), 1'b0, '0, '0);
		add_row(sample_t'(-4), 1'b0, '0, '0);
		add_row(sample_t'(-3), 1'b0, '0, '0);
		add_row(sample_t'(32'h8000_0000), 1'b0, '0, '0);
		add_row(sample_t'(32'h7FFF_FFFF), 1'b0, '0, '0);
	endtask

	// Holds the beat until it is taken, then records what the tracker should report for it.
	task automatic offer(input sample_t value, input bit typed, input median_result_t typed_result);
		median_result_t predicted;
		sample_valid <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		predicted = track_median(value);
		samples_sent++;
		if (predicted.dropped)
			drops_predicted++;
		if (int'(predicted.held) > peak_held)
			peak_held = int'(predicted.held);
		if (typed)
			predicted = typed_result;
		expected_medians = {expected_medians, predicted};
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			sample_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			seen.median = median_doubled;
			seen.held = held_count;
			seen.dropped = dropped;
			if (expected_medians.size() == 0) begin
				$error("unexpected result beat: median_doubled %0d held_count %0d dropped %0b",
					median_doubled, held_count, dropped);
				failures++;
			end else begin
				want = expected_medians.pop_front();
				if (seen.median !== want.median) begin
					$error("median_doubled: expected %0d, got %0d", want.median, seen.median);
					failures++;
				end
				if (seen.held !== want.held) begin
					$error("held_count: expected %0d, got %0d", want.held, seen.held);
					failures++;
				end
				if (seen.dropped !== want.dropped) begin
					$error("dropped: expected %0b, got %0b", want.dropped, seen.dropped);
					failures++;
				end
			end
			results_checked++;
		end
	end

	initial begin : result_sink
		int hold_left;
		bit long_hold_done;
		hold_left = 0;
		long_hold_done = 1'b0;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			// One long back-pressure stretch so the tracker holds its result and stalls its input.
			if (!long_hold_done && results_checked >= HOLD_AT) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				result_ready <= 1'b1;
				if (!in_quiet_stretch(results_checked))
					hold_left = pick_gap();
			end
		end
	end

	initial begin : stimulus
		sample_t last;
		int waited;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		heap_count[LOWER_HALF] = 0;
		heap_count[UPPER_HALF] = 0;
		last = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_directed_rows();
		foreach (directed_rows[i]) begin
			offer(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].result);
			idle_sender(pick_gap());
		end

		while (samples_sent < TOTAL_SAMPLES) begin
			if (samples_sent == DRAIN_PAUSE) begin
				sample_valid <= 1'b0;
				@(posedge clk);
				while (expected_medians.size() != 0)
					@(posedge clk);
			end
			last = draw_sample(last);
			offer(last, 1'b0, '0);
			if (!in_quiet_stretch(samples_sent))
				idle_sender(pick_gap());
		end
		sample_valid <= 1'b0;

		waited = 0;
		while (expected_medians.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_medians.size() != 0) begin
			$error("%0d expected results never arrived", expected_medians.size());
			failures++;
		end

		$display("Covered %0d samples (extremes, ties, clusters, near-median values); the store",
			samples_sent);
		$display("peaked at %0d held, %0d samples dropped when full, %0d results checked.",
			peak_held, drops_predicted, results_checked);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/rmt_pkg.sv
hw/rtl/rmt_cell.sv
hw/rtl/rmt_heap.sv
hw/rtl/running_median_tracker_top.sv
test/testbench.sv
